// ----- design/utf8cs_pkg.sv -----
package utf8cs_pkg;

    localparam int unsigned CfgWidth   = 32;
    localparam int unsigned CountWidth = 31;
    localparam int unsigned LeftWidth  = 3;
    localparam int unsigned MaxLeadOnes = 4;

    localparam logic [0:0] REG_START  = 1'b0;
    localparam logic [0:0] REG_LENGTH = 1'b1;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_NEG_LEN   = 3'd1;
    localparam logic [2:0] ST_NEG_START = 3'd2;
    localparam logic [2:0] ST_CONT_LEAD = 3'd3;
    localparam logic [2:0] ST_LEAD_LONG = 3'd4;

    typedef enum logic [2:0] {
        PH_SKIP = 3'b001,
        PH_PASS = 3'b010,
        PH_DONE = 3'b100
    } t_phase;

    typedef struct packed {
        logic       keep;
        logic [2:0] status;
    } t_result;

    function automatic logic [3:0] leading_ones(input logic [7:0] b);
        logic [3:0] n;
        logic       run;
        n   = 4'd0;
        run = 1'b1;
        for (int i = 7; i >= 0; i--) begin
            if (run && b[i]) begin
                n = n + 4'd1;
            end else begin
                run = 1'b0;
            end
        end
        return n;
    endfunction

endpackage

// ----- design/utf8cs_in_if.sv -----
interface utf8cs_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

// ----- design/utf8cs_out_if.sv -----
interface utf8cs_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       keep;
    logic [2:0] status;
    logic       end_of_string;

    modport source (output valid, output out_byte, output keep, output status,
                    output end_of_string, input ready);
    modport sink   (input valid, input out_byte, input keep, input status,
                    input end_of_string, output ready);
endinterface

// ----- design/utf8cs_core.sv -----
module utf8cs_core
    import utf8cs_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_advance,
    input  logic [7:0]          i_data_byte,
    input  logic                i_last_byte,
    input  logic [CfgWidth-1:0] i_start,
    input  logic [CfgWidth-1:0] i_length,
    output t_result             o_result
);

    t_phase                r_phase, n_phase;
    logic [CountWidth-1:0] r_count, n_count;
    logic [LeftWidth-1:0]  r_left,  n_left;
    logic [2:0]            r_sticky, n_sticky;

    always_comb begin
        t_phase                ph;
        logic [CountWidth-1:0] cnt;
        logic [3:0]            ones;
        logic [2:0]            st;
        logic                  keep;

        ph      = r_phase;
        cnt     = r_count;
        st      = r_sticky;
        keep    = 1'b0;
        ones    = leading_ones(i_data_byte);
        n_left  = r_left;

        if (st == ST_OK) begin
            if (i_length[CfgWidth-1]) begin
                st = ST_NEG_LEN;
            end else if (i_start[CfgWidth-1]) begin
                st = ST_NEG_START;
            end
        end

        if (st == ST_OK) begin
            if (r_left != '0) begin
                n_left = r_left - LeftWidth'(1);
                keep   = (ph == PH_PASS);
            end else begin
                if (ph == PH_SKIP && {1'b0, cnt} >= i_start) begin
                    ph  = PH_PASS;
                    cnt = '0;
                end
                if (ph == PH_PASS && {1'b0, cnt} >= i_length) begin
                    ph = PH_DONE;
                end
                if (ph != PH_DONE) begin
                    if (ones == 4'd1) begin
                        st = ST_CONT_LEAD;
                    end else if (ones > 4'(MaxLeadOnes)) begin
                        st = ST_LEAD_LONG;
                    end else begin
                        n_left = (ones == 4'd0) ? '0 : LeftWidth'(ones - 4'd1);
                        cnt    = cnt + CountWidth'(1);
                        keep   = (ph == PH_PASS);
                    end
                end
            end
        end

        n_phase  = ph;
        n_count  = cnt;
        n_sticky = st;
        o_result = '{keep: keep, status: st};

        if (i_last_byte) begin
            n_phase  = PH_SKIP;
            n_count  = '0;
            n_left   = '0;
            n_sticky = ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_SKIP;
            r_count  <= '0;
            r_left   <= '0;
            r_sticky <= ST_OK;
        end else if (i_advance) begin
            r_phase  <= n_phase;
            r_count  <= n_count;
            r_left   <= n_left;
            r_sticky <= n_sticky;
        end
    end

endmodule

// ----- design/utf8_codepoint_substring_unit.sv -----
// UTF-8 code point substring unit.
// Input channel i_in carries one string byte per request with a last-byte
// flag; output channel o_out returns one result per byte: the byte itself,
// a keep flag, a status code and the end-of-string flag.
// The APB port holds the start and length settings (code points, signed),
// at byte addresses 0 and 4; write them only while no string is in flight.
// Latency: a result is valid the cycle after its request is accepted.
// Throughput: one byte per cycle while o_out.ready stays high; the per-byte
// state update (counter compare and lead-byte decode) sits between the state
// registers and the result register.
// A result waiting in the output register while o_out.ready is low holds;
// a new request is then taken only in the cycle the waiting result leaves.
// A nonzero status sticks until the last byte of the string; after the last
// byte the string state returns to its start, the settings are kept.
// Reset is synchronous: the output register empties, the string state
// clears and both settings return to zero.
module utf8_codepoint_substring_unit
    import utf8cs_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    utf8cs_in_if.sink            i_in,
    utf8cs_out_if.source         o_out,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [CfgWidth-1:0]  pwdata,
    output logic [CfgWidth-1:0]  prdata,
    output logic                 pready
);

    logic [CfgWidth-1:0] r_start;
    logic [CfgWidth-1:0] r_length;
    logic                r_out_valid;
    logic [7:0]          r_out_byte;
    t_result             r_out_result;
    logic                r_out_last;
    logic                accept;
    logic                cfg_write;
    t_result             result;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[2] == REG_LENGTH) ? r_length : r_start;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start  <= '0;
            r_length <= '0;
        end else if (cfg_write) begin
            if (paddr[2] == REG_START) begin
                r_start <= pwdata;
            end else begin
                r_length <= pwdata;
            end
        end
    end

    assign i_in.ready = !r_out_valid || o_out.ready;
    assign accept     = i_in.valid && i_in.ready;

    utf8cs_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_advance   (accept),
        .i_data_byte (i_in.data_byte),
        .i_last_byte (i_in.last_byte),
        .i_start     (r_start),
        .i_length    (r_length),
        .o_result    (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_byte   <= i_in.data_byte;
            r_out_result <= result;
            r_out_last   <= i_in.last_byte;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.out_byte      = r_out_byte;
    assign o_out.keep          = r_out_result.keep;
    assign o_out.status        = r_out_result.status;
    assign o_out.end_of_string = r_out_last;

`ifndef SYNTHESIS
    a_accept_fills_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> o_out.valid)
        else $error("accepted request produced no result");

    a_failed_byte_dropped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.status != ST_OK) |-> !o_out.keep)
        else $error("byte kept under a failure status");

    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.status <= ST_LEAD_LONG))
        else $error("status code out of range");
`endif

endmodule

// ----- tb/sv/tb_utf8_codepoint_substring_unit.sv -----
`timescale 1ns / 1ps

module tb_utf8_codepoint_substring_unit;
    import utf8cs_pkg::*;

    typedef struct {
        logic [7:0] out_byte;
        logic       keep;
        logic [2:0] status;
        logic       end_of_string;
    } t_expected_byte;

    class substring_tracker;
        logic [31:0]    start_cp;
        logic [31:0]    length_cp;
        t_phase         cp_phase;
        logic [30:0]    cp_count;
        logic [2:0]     left_in_point;
        logic [2:0]     sticky;
        t_expected_byte due_results[$];
        int             errors;
        int             kept_bytes;
        int             status_seen[5];

        function new();
            start_cp   = '0;
            length_cp  = '0;
            errors     = 0;
            kept_bytes = 0;
            foreach (status_seen[i]) status_seen[i] = 0;
            clear_string();
        endfunction

        function void clear_string();
            cp_phase      = PH_SKIP;
            cp_count      = '0;
            left_in_point = '0;
            sticky        = ST_OK;
        endfunction

        function void set_register(logic [0:0] idx, logic [31:0] value);
            if (idx == REG_START) begin
                start_cp = value;
            end else begin
                length_cp = value;
            end
        endfunction

        function int lead_ones(logic [7:0] b);
            casez (b)
                8'b0???????: return 0;
                8'b10??????: return 1;
                8'b110?????: return 2;
                8'b1110????: return 3;
                8'b11110???: return 4;
                default:     return 5;
            endcase
        endfunction

        function void note_byte(logic [7:0] b, logic last_flag);
            t_expected_byte exp;
            int             ones;
            exp.keep = 1'b0;
            if (sticky == ST_OK) begin
                if (length_cp[31]) begin
                    sticky = ST_NEG_LEN;
                end else if (start_cp[31]) begin
                    sticky = ST_NEG_START;
                end
            end
            if (sticky == ST_OK) begin
                if (left_in_point != 0) begin
                    left_in_point = left_in_point - 3'd1;
                    exp.keep = (cp_phase == PH_PASS);
                end else begin
                    if (cp_phase == PH_SKIP && {1'b0, cp_count} >= start_cp) begin
                        cp_phase = PH_PASS;
                        cp_count = '0;
                    end
                    if (cp_phase == PH_PASS && {1'b0, cp_count} >= length_cp) begin
                        cp_phase = PH_DONE;
                    end
                    if (cp_phase != PH_DONE) begin
                        ones = lead_ones(b);
                        if (ones == 1) begin
                            sticky = ST_CONT_LEAD;
                        end else if (ones > MaxLeadOnes) begin
                            sticky = ST_LEAD_LONG;
                        end else begin
                            left_in_point = (ones == 0) ? 3'd0 : 3'(ones - 1);
                            cp_count = cp_count + 31'd1;
                            exp.keep = (cp_phase == PH_PASS);
                        end
                    end
                end
            end
            exp.out_byte      = b;
            exp.status        = sticky;
            exp.end_of_string = last_flag;
            due_results.push_back(exp);
            if (last_flag) begin
                clear_string();
            end
        endfunction

        function void check_result(logic [7:0] b, logic k, logic [2:0] st, logic e);
            t_expected_byte exp;
            if (due_results.size() == 0) begin
                $display("%0t: result with nothing due: byte %02h keep %0b status %0d",
                         $time, b, k, st);
                errors++;
                return;
            end
            exp = due_results.pop_front();
            if (b !== exp.out_byte) begin
                $display("%0t: out_byte expected %02h actual %02h", $time, exp.out_byte, b);
                errors++;
            end
            if (k !== exp.keep) begin
                $display("%0t: keep expected %0b actual %0b (byte %02h)",
                         $time, exp.keep, k, exp.out_byte);
                errors++;
            end
            if (st !== exp.status) begin
                $display("%0t: status expected %0d actual %0d (byte %02h)",
                         $time, exp.status, st, exp.out_byte);
                errors++;
            end
            if (e !== exp.end_of_string) begin
                $display("%0t: end_of_string expected %0b actual %0b",
                         $time, exp.end_of_string, e);
                errors++;
            end
            if (exp.keep) kept_bytes++;
            if (exp.status <= ST_LEAD_LONG) status_seen[exp.status]++;
        endfunction
    endclass

    logic                i_clk;
    logic                i_rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [2:0]          paddr;
    logic [CfgWidth-1:0] pwdata;
    logic [CfgWidth-1:0] prdata;
    logic                pready;

    utf8cs_in_if  in_if ();
    utf8cs_out_if out_if ();

    utf8_codepoint_substring_unit u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    substring_tracker tracker = new();
    logic [7:0]       text_bytes[$];
    int               bytes_sent;
    int               strings_sent;
    int               settings_used;

    localparam logic [31:0] CORNER_VALUES [5] = '{
        32'h0000_0000, 32'h0000_0001, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF
    };

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #10_000_000;
        $display("utf8_codepoint_substring_unit: mismatch");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (in_if.valid && in_if.ready) begin
                tracker.note_byte(in_if.data_byte, in_if.last_byte);
            end
            if (out_if.valid && out_if.ready) begin
                tracker.check_result(out_if.out_byte, out_if.keep, out_if.status,
                                     out_if.end_of_string);
            end
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // receiver: random stalls with occasional long stretches held ready
    initial begin
        int hold;
        out_if.ready = 1'b0;
        forever begin
            if ($urandom_range(0, 24) == 0) begin
                repeat ($urandom_range(30, 100)) begin
                    @(negedge i_clk);
                    out_if.ready <= 1'b1;
                end
            end
            hold = pick_gap();
            repeat (hold) begin
                @(negedge i_clk);
                out_if.ready <= 1'b0;
            end
            @(negedge i_clk);
            out_if.ready <= 1'b1;
        end
    end

    task automatic wait_drained();
        @(posedge i_clk);
        while (tracker.due_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic apb_write(input logic [0:0] idx, input logic [31:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        tracker.set_register(idx, value);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic write_settings(input logic [31:0] start_v, input logic [31:0] length_v);
        @(negedge i_clk);
        in_if.valid <= 1'b0;
        wait_drained();
        apb_write(REG_START, start_v);
        apb_write(REG_LENGTH, length_v);
        settings_used++;
    endtask

    task automatic send_byte(input logic [7:0] b, input logic last_flag, input bit eager);
        int gap;
        gap = eager ? 0 : pick_gap();
        repeat (gap) begin
            @(negedge i_clk);
            in_if.valid <= 1'b0;
        end
        @(negedge i_clk);
        in_if.valid     <= 1'b1;
        in_if.data_byte <= b;
        in_if.last_byte <= last_flag;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        bytes_sent++;
    endtask

    task automatic send_text();
        bit eager;
        eager = ($urandom_range(0, 3) == 0);
        foreach (text_bytes[i]) begin
            send_byte(text_bytes[i], i == text_bytes.size() - 1, eager);
        end
        strings_sent++;
        if ($urandom_range(0, 19) == 0) begin
            @(negedge i_clk);
            in_if.valid <= 1'b0;
            wait_drained();
        end
    endtask

    function automatic void push_lead(int n);
        logic [31:0] r;
        r = $urandom;
        case (n)
            1:       text_bytes.push_back({1'b0, r[6:0]});
            2:       text_bytes.push_back({3'b110, r[4:0]});
            3:       text_bytes.push_back({4'b1110, r[3:0]});
            default: text_bytes.push_back({5'b11110, r[2:0]});
        endcase
    endfunction

    function automatic void push_cont();
        logic [31:0] r;
        r = $urandom;
        if ($urandom_range(0, 9) == 0) begin
            text_bytes.push_back(r[7:0]);
        end else begin
            text_bytes.push_back({2'b10, r[5:0]});
        end
    endfunction

    function automatic void build_text();
        logic [31:0] r;
        int          kind;
        int          n;
        text_bytes.delete();
        kind = $urandom_range(0, 9);
        if (kind == 0) begin
            repeat ($urandom_range(1, 10)) begin
                r = $urandom;
                text_bytes.push_back(r[7:0]);
            end
        end else begin
            repeat ($urandom_range(1, 12)) begin
                n = $urandom_range(1, 4);
                if ($urandom_range(0, 29) == 0) begin
                    r = $urandom;
                    text_bytes.push_back(r[8] ? {2'b10, r[5:0]} : {5'b11111, r[2:0]});
                end else begin
                    push_lead(n);
                    repeat (n - 1) push_cont();
                end
            end
            if (kind == 1) begin
                n = $urandom_range(2, 4);
                push_lead(n);
                repeat ($urandom_range(0, n - 2)) push_cont();
            end
        end
    endfunction

    task automatic pick_settings();
        logic [31:0] start_v;
        logic [31:0] length_v;
        int          r;
        r = $urandom_range(0, 9);
        if (r < 3) begin
            start_v  = CORNER_VALUES[$urandom_range(0, 4)];
            length_v = CORNER_VALUES[$urandom_range(0, 4)];
        end else if (r == 3) begin
            start_v  = $urandom;
            length_v = $urandom;
        end else begin
            start_v  = $urandom_range(0, 6);
            length_v = $urandom_range(0, 6);
        end
        write_settings(start_v, length_v);
    endtask

    initial begin
        i_rst_n         = 1'b0;
        in_if.valid     = 1'b0;
        in_if.data_byte = '0;
        in_if.last_byte = 1'b0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        bytes_sent      = 0;
        strings_sent    = 0;
        settings_used   = 0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        text_bytes = '{8'h41};
        send_text();
        write_settings(32'd1, 32'd2);
        text_bytes = '{8'h41, 8'hC3, 8'hA9, 8'hF0, 8'h9F, 8'h98, 8'h80, 8'h7F, 8'h80};
        send_text();
        text_bytes = '{8'h80, 8'hFF, 8'h41};
        send_text();
        text_bytes = '{8'h41, 8'hF8, 8'h41};
        send_text();
        text_bytes = '{8'hE2, 8'h82, 8'hAC, 8'hF0, 8'h9F};
        send_text();
        write_settings(32'd1, 32'hFFFF_FFFF);
        text_bytes = '{8'h41};
        send_text();
        write_settings(32'h8000_0000, 32'd2);
        text_bytes = '{8'h41};
        send_text();

        while (bytes_sent < 1150) begin
            pick_settings();
            repeat ($urandom_range(1, 4)) begin
                build_text();
                send_text();
            end
        end

        @(negedge i_clk);
        in_if.valid <= 1'b0;
        wait_drained();
        repeat (10) @(posedge i_clk);

        $display("covered %0d bytes in %0d strings under %0d settings, %0d bytes kept",
                 bytes_sent, strings_sent, settings_used, tracker.kept_bytes);
        $display("status seen: ok %0d, neg length %0d, neg start %0d, cont lead %0d, long lead %0d",
                 tracker.status_seen[0], tracker.status_seen[1], tracker.status_seen[2],
                 tracker.status_seen[3], tracker.status_seen[4]);
        if (tracker.errors == 0 && tracker.due_results.size() == 0) begin
            $display("utf8_codepoint_substring_unit: match");
        end else begin
            $display("utf8_codepoint_substring_unit: mismatch");
        end
        $finish;
    end

endmodule
